[hw/rtl/sbr_pkg.sv]
package sbr_pkg;

    localparam int WORD_W = 16;
    localparam int DVD_W  = 23;
    localparam int CNT_W  = 5;
    localparam int SOC_W  = 7;

    localparam logic [2:0] REQ_READ    = 3'd0;
    localparam logic [2:0] REQ_PRESET  = 3'd1;
    localparam logic [2:0] REQ_STATUS  = 3'd2;
    localparam logic [2:0] REQ_SOC     = 3'd3;
    localparam logic [2:0] REQ_TEMP    = 3'd4;
    localparam logic [2:0] REQ_LIMIT   = 3'd5;

    localparam logic [7:0] CMD_TEMPERATURE  = 8'h08;
    localparam logic [7:0] CMD_VOLTAGE      = 8'h09;
    localparam logic [7:0] CMD_CURRENT      = 8'h0A;
    localparam logic [7:0] CMD_AVG_CURRENT  = 8'h0B;
    localparam logic [7:0] CMD_REL_SOC      = 8'h0D;
    localparam logic [7:0] CMD_ABS_SOC      = 8'h0E;
    localparam logic [7:0] CMD_REMAINING    = 8'h0F;
    localparam logic [7:0] CMD_FULL_CAP     = 8'h10;
    localparam logic [7:0] CMD_RUN_EMPTY    = 8'h11;
    localparam logic [7:0] CMD_AVG_EMPTY    = 8'h12;
    localparam logic [7:0] CMD_STATUS       = 8'h16;
    localparam logic [7:0] CMD_CYCLES       = 8'h17;
    localparam logic [7:0] CMD_DESIGN_CAP   = 8'h18;
    localparam logic [7:0] CMD_DESIGN_VOLT  = 8'h19;
    localparam logic [7:0] CMD_MFG_DATE     = 8'h1B;
    localparam logic [7:0] CMD_SERIAL       = 8'h1C;
    localparam logic [7:0] CMD_SVC_FLAGS    = 8'h60;
    localparam logic [7:0] CMD_CHARGE_LIMIT = 8'h61;

    localparam int FLAG_MAINT = 0;
    localparam int FLAG_SHIP  = 1;
    localparam int FLAG_FAIL  = 2;

    localparam int STATUS_SHIP_BIT = 9;
    localparam int STATUS_FAIL_BIT = 10;

    localparam logic [WORD_W-1:0] TEMP_OFFSET = 16'd273;
    localparam logic [SOC_W-1:0]  PCT_FULL    = 7'd100;
    localparam logic [SOC_W-1:0]  MIN_PER_HR  = 7'd60;
    localparam logic [WORD_W-1:0] MIN_CURRENT = 16'd100;

    localparam int MFG_YEAR  = 2026;
    localparam int MFG_EPOCH = 1980;
    localparam logic [WORD_W-1:0] MFG_DATE_WORD =
        16'(((MFG_YEAR - MFG_EPOCH) << 9) | (9 << 5) | 3);

    typedef struct packed {
        logic [WORD_W-1:0] voltage;
        logic [WORD_W-1:0] full_cap;
        logic [WORD_W-1:0] remaining;
        logic [WORD_W-1:0] current;
        logic [WORD_W-1:0] avg_current;
        logic [WORD_W-1:0] temperature;
        logic [WORD_W-1:0] cycles;
        logic [WORD_W-1:0] serial;
        logic [WORD_W-1:0] status;
        logic [WORD_W-1:0] limit;
        logic [2:0]        flags;
    } rec_t;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    function automatic rec_t preset_rec(input logic [2:0] idx);
        rec_t r;
        case (idx)
            3'd0: r = '{16'd11400, 16'd5400, 16'd4300, 16'hFA56, 16'hFB50, 16'd31,
                        16'd126, 16'h4912, 16'h0080, 16'd3200, 3'b000};
            3'd1: r = '{16'd7600, 16'd6800, 16'd5200, 16'hFC68, 16'hFCD6, 16'd29,
                        16'd44, 16'h7811, 16'h0040, 16'd2100, 3'b000};
            3'd2: r = '{16'd22200, 16'd4200, 16'd2100, 16'hF1F0, 16'hF510, 16'd37,
                        16'd87, 16'h2620, 16'h0100, 16'd4500, 3'b000};
            3'd3: r = '{16'd11400, 16'd6000, 16'd5900, 16'hFE70, 16'hFEA2, 16'd28,
                        16'd3, 16'h9001, 16'h0000, 16'd3400, 3'b001};
            default: r = '{16'd11220, 16'd3900, 16'd2700, 16'hFA24, 16'hFA24, 16'd41,
                           16'd1, 16'h1111, 16'h0400, 16'd900, 3'b000};
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/sbr_div.sv]
module sbr_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbr_pkg::div_req_t req,
    output sbr_pkg::div_rsp_t rsp
);
    import sbr_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hw/rtl/smart_battery_data_responder.sv]
// Smart Battery word responder. Each request beat returns exactly one result
// beat: the word for a read, zero for every write and unknown command. One
// request is in flight at a time. State of charge reads with a nonzero full
// capacity, time-to-empty reads and state-of-charge writes pass through a
// 23-step bit-serial divider that all three share behind one 16x7 multiplier;
// direct reads and writes do not. A result waiting on m_ready holds the
// block: the next request is taken only once the previous result has been
// loaded into the output register.
module smart_battery_data_responder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_command,
    input  logic [15:0] s_write_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data
);
    import sbr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_DIVGO = 3'd2;
    localparam logic [2:0] ST_DIVWT = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [1:0] OP_SOC_RD = 2'd0;
    localparam logic [1:0] OP_TTE_RD = 2'd1;
    localparam logic [1:0] OP_SOC_WR = 2'd2;

    logic [2:0]        state_reg, state_next;
    rec_t              rec_reg, rec_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] m_data_reg, m_data_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [2:0]        req_reg, req_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [1:0]        op_reg, op_next;
    logic [DVD_W-1:0]  prod_reg, prod_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;

    logic [WORD_W-1:0] mul_a;
    logic [SOC_W-1:0]  mul_b;
    logic [DVD_W-1:0]  product;
    logic [WORD_W-1:0] sel_current;
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] temp_k;
    logic [2:0]        preset_idx;
    logic [SOC_W-1:0]  soc_pct;
    logic              use_div;
    logic              out_free;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    sbr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign product = DVD_W'({7'd0, mul_a} * {16'd0, mul_b});
    assign sel_current = (cmd_reg == CMD_AVG_EMPTY) ? rec_reg.avg_current : rec_reg.current;
    // -32768 negates to 0x8000, which is its magnitude read as unsigned
    assign mag = sel_current[WORD_W-1] ? (~sel_current + 1'b1) : sel_current;
    assign temp_k = ((rec_reg.temperature + TEMP_OFFSET) << 3) +
                    ((rec_reg.temperature + TEMP_OFFSET) << 1);
    assign preset_idx = (val_reg > 16'd4) ? 3'd4 : val_reg[2:0];
    assign soc_pct = (val_reg > {9'd0, PCT_FULL}) ? PCT_FULL : val_reg[SOC_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        use_div = 1'b0;
        op_next = op_reg;
        mul_a   = rec_reg.remaining;
        mul_b   = PCT_FULL;
        if (req_reg == REQ_READ) begin
            case (cmd_reg)
                CMD_REL_SOC, CMD_ABS_SOC: begin
                    use_div = rec_reg.full_cap != '0;
                    op_next = OP_SOC_RD;
                end
                CMD_RUN_EMPTY, CMD_AVG_EMPTY: begin
                    use_div = 1'b1;
                    op_next = OP_TTE_RD;
                    mul_b   = MIN_PER_HR;
                end
                default: ;
            endcase
        end else if (req_reg == REQ_SOC) begin
            use_div = 1'b1;
            op_next = OP_SOC_WR;
            mul_a   = rec_reg.full_cap;
            mul_b   = soc_pct;
        end
    end

    always_comb begin
        state_next   = state_reg;
        rec_next     = rec_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        res_next     = res_reg;
        req_next     = req_reg;
        cmd_next     = cmd_reg;
        val_next     = val_reg;
        prod_next    = prod_reg;
        dvs_next     = dvs_reg;
        div_req      = '{start: 1'b0, dividend: prod_reg, divisor: dvs_reg};
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    cmd_next   = s_command;
                    val_next   = s_write_value;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next = '0;
                if (use_div) begin
                    prod_next  = product;
                    dvs_next   = (op_next == OP_SOC_WR) ? {9'd0, PCT_FULL} :
                                 (op_next == OP_TTE_RD) ?
                                 ((mag < MIN_CURRENT) ? MIN_CURRENT : mag) :
                                 rec_reg.full_cap;
                    state_next = ST_DIVGO;
                end else begin
                    state_next = ST_FIN;
                    case (req_reg)
                        REQ_READ: begin
                            case (cmd_reg)
                                CMD_TEMPERATURE:  res_next = temp_k;
                                CMD_VOLTAGE,
                                CMD_DESIGN_VOLT:  res_next = rec_reg.voltage;
                                CMD_CURRENT:      res_next = rec_reg.current;
                                CMD_AVG_CURRENT:  res_next = rec_reg.avg_current;
                                CMD_REMAINING:    res_next = rec_reg.remaining;
                                CMD_FULL_CAP,
                                CMD_DESIGN_CAP:   res_next = rec_reg.full_cap;
                                CMD_STATUS:       res_next = rec_reg.status;
                                CMD_CYCLES:       res_next = rec_reg.cycles;
                                CMD_MFG_DATE:     res_next = MFG_DATE_WORD;
                                CMD_SERIAL:       res_next = rec_reg.serial;
                                CMD_SVC_FLAGS:    res_next = {13'd0, rec_reg.flags};
                                CMD_CHARGE_LIMIT: res_next = rec_reg.limit;
                                default:          res_next = '0;
                            endcase
                        end
                        REQ_PRESET: rec_next = preset_rec(preset_idx);
                        REQ_STATUS: begin
                            rec_next.status           = val_reg;
                            rec_next.flags[FLAG_SHIP] = val_reg[STATUS_SHIP_BIT];
                            rec_next.flags[FLAG_FAIL] = val_reg[STATUS_FAIL_BIT];
                        end
                        REQ_TEMP:  rec_next.temperature = val_reg;
                        REQ_LIMIT: rec_next.limit       = val_reg;
                        default: ;
                    endcase
                end
            end
            ST_DIVGO: begin
                div_req.start = 1'b1;
                state_next    = ST_DIVWT;
            end
            ST_DIVWT: begin
                if (div_rsp.done) begin
                    state_next = ST_FIN;
                    case (op_reg)
                        OP_SOC_RD: res_next = (div_rsp.quotient > DVD_W'(PCT_FULL)) ?
                                              {9'd0, PCT_FULL} :
                                              div_rsp.quotient[WORD_W-1:0];
                        OP_TTE_RD: res_next = div_rsp.quotient[WORD_W-1:0];
                        default:   rec_next.remaining = div_rsp.quotient[WORD_W-1:0];
                    endcase
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            rec_reg     <= '0;
            op_reg      <= OP_SOC_RD;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rec_reg     <= rec_next;
            op_reg      <= (state_reg == ST_EXEC) ? op_next : op_reg;
        end
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
        req_reg    <= req_next;
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        prod_reg   <= prod_next;
        dvs_reg    <= dvs_next;
    end

    assign s_ready     = state_reg == ST_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

endmodule

[verif/sbr_word_checker.sv]
module sbr_word_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_command,
    input  logic [15:0] s_write_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_read_data,
    output int          fail_count,
    output int          pending,
    output int          results_checked
);
    import sbr_pkg::*;

    typedef struct packed {
        logic [15:0] voltage;
        logic [15:0] full_cap;
        logic [15:0] remaining;
        logic [15:0] current;
        logic [15:0] avg_current;
        logic [15:0] temperature;
        logic [15:0] cycles;
        logic [15:0] serial;
        logic [15:0] status;
        logic [15:0] limit;
        logic [2:0]  flags;
    } battery_pack_t;

    battery_pack_t batt;
    logic [15:0]   expected_words[$];

    // run time left in minutes; currents below 100 mA count as 100 mA
    function automatic logic [15:0] minutes_left(input logic [15:0] rem,
                                                 input logic [15:0] cur);
        logic [31:0] mag;
        logic [31:0] quot;
        mag = cur[15] ? (32'h0001_0000 - {16'b0, cur}) : {16'b0, cur};
        if (mag < 32'd100) mag = 32'd100;
        quot = ({16'b0, rem} * 32'd60) / mag;
        return quot[15:0];
    endfunction

    // apply one request to the battery record and return the answered word
    function automatic logic [15:0] battery_word(input logic [2:0]  rt,
                                                 input logic [7:0]  cmd,
                                                 input logic [15:0] wv);
        logic [15:0] word;
        logic [15:0] pct;
        logic [31:0] quot;
        logic [2:0]  idx;
        word = '0;
        case (rt)
            REQ_READ: begin
                case (cmd)
                    CMD_TEMPERATURE:  word = (batt.temperature + 16'd273) * 16'd10;
                    CMD_VOLTAGE,
                    CMD_DESIGN_VOLT:  word = batt.voltage;
                    CMD_CURRENT:      word = batt.current;
                    CMD_AVG_CURRENT:  word = batt.avg_current;
                    CMD_REL_SOC,
                    CMD_ABS_SOC: begin
                        if (batt.full_cap != 16'd0) begin
                            quot = ({16'b0, batt.remaining} * 32'd100) /
                                   {16'b0, batt.full_cap};
                            word = (quot > 32'd100) ? 16'd100 : quot[15:0];
                        end
                    end
                    CMD_REMAINING:    word = batt.remaining;
                    CMD_FULL_CAP,
                    CMD_DESIGN_CAP:   word = batt.full_cap;
                    CMD_RUN_EMPTY:    word = minutes_left(batt.remaining, batt.current);
                    CMD_AVG_EMPTY:    word = minutes_left(batt.remaining, batt.avg_current);
                    CMD_STATUS:       word = batt.status;
                    CMD_CYCLES:       word = batt.cycles;
                    CMD_MFG_DATE:     word = 16'h5D23;
                    CMD_SERIAL:       word = batt.serial;
                    CMD_SVC_FLAGS:    word = {13'b0, batt.flags};
                    CMD_CHARGE_LIMIT: word = batt.limit;
                    default:          word = '0;
                endcase
            end
            REQ_PRESET: begin
                idx = (wv > 16'd4) ? 3'd4 : wv[2:0];
                case (idx)
                    3'd0: batt = {16'd11400, 16'd5400, 16'd4300, 16'hFA56, 16'hFB50,
                                  16'd31, 16'd126, 16'h4912, 16'h0080, 16'd3200, 3'b000};
                    3'd1: batt = {16'd7600, 16'd6800, 16'd5200, 16'hFC68, 16'hFCD6,
                                  16'd29, 16'd44, 16'h7811, 16'h0040, 16'd2100, 3'b000};
                    3'd2: batt = {16'd22200, 16'd4200, 16'd2100, 16'hF1F0, 16'hF510,
                                  16'd37, 16'd87, 16'h2620, 16'h0100, 16'd4500, 3'b000};
                    3'd3: batt = {16'd11400, 16'd6000, 16'd5900, 16'hFE70, 16'hFEA2,
                                  16'd28, 16'd3, 16'h9001, 16'h0000, 16'd3400, 3'b001};
                    default: batt = {16'd11220, 16'd3900, 16'd2700, 16'hFA24, 16'hFA24,
                                     16'd41, 16'd1, 16'h1111, 16'h0400, 16'd900, 3'b000};
                endcase
            end
            REQ_STATUS: begin
                // maintenance survives a status write
                batt.status = wv;
                batt.flags[FLAG_SHIP] = wv[STATUS_SHIP_BIT];
                batt.flags[FLAG_FAIL] = wv[STATUS_FAIL_BIT];
            end
            REQ_SOC: begin
                pct = (wv > 16'd100) ? 16'd100 : wv;
                quot = ({16'b0, batt.full_cap} * {16'b0, pct}) / 32'd100;
                batt.remaining = quot[15:0];
            end
            REQ_TEMP:  batt.temperature = wv;
            REQ_LIMIT: batt.limit = wv;
            default: ;
        endcase
        return word;
    endfunction

    always @(posedge aclk) begin : watch
        logic [15:0] want;
        if (!aresetn) begin
            batt = '0;
            expected_words.delete();
            fail_count = 0;
            pending = 0;
            results_checked = 0;
        end else begin
            // queue the new request first so a same-edge result still pairs in order
            if (s_valid && s_ready)
                expected_words.push_back(battery_word(s_req_type, s_command,
                                                      s_write_value));
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat: expected none, got 0x%04h",
                             $time, m_read_data);
                end else begin
                    want = expected_words.pop_front();
                    if (m_read_data !== want) begin
                        fail_count++;
                        $display("%0t: read_data mismatch: expected 0x%04h, got 0x%04h",
                                 $time, want, m_read_data);
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

[verif/tb_smart_battery_data_responder.sv]
module tb_smart_battery_data_responder;
    import sbr_pkg::*;

    localparam int RANDOM_REQS      = 1125;
    localparam int LONG_HOLD_CYCLES = 200;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_req_type;
    logic [7:0]  s_command;
    logic [15:0] s_write_value;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_read_data;

    int fail_count;
    int pending;
    int results_checked;

    int  reads_sent;
    int  writes_sent;
    int  unused_sent;
    bit  free_run;
    bit  hold_off_go;
    bit  hold_off_done;

    smart_battery_data_responder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_command     (s_command),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data)
    );

    sbr_word_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_command       (s_command),
        .s_write_value   (s_write_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // offer one request beat, hold it until accepted, then rest a random gap
    task automatic send_request(input logic [2:0] rt, input logic [7:0] cmd,
                                input logic [15:0] wv);
        int r;
        int gap;
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_command <= cmd;
        s_write_value <= wv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (rt == REQ_READ) reads_sent++;
        else if (rt <= REQ_LIMIT) writes_sent++;
        else unused_sent++;
        r = $urandom_range(0, 99);
        if (free_run || r < 60) gap = 0;
        else if (r < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // result side: random stalls, one long hold-off, and a free-running stretch
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_go && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
                hold_off_done = 1'b1;
            end else if (free_run || $urandom_range(0, 99) < 65) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 99) < 8) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge aclk);
            end else begin
                m_ready <= 1'b0;
            end
        end
    end

    initial begin
        int          pick;
        logic [2:0]  rt;
        logic [7:0]  cmd;
        logic [15:0] wv;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = '0;
        s_command = '0;
        s_write_value = '0;
        reads_sent = 0;
        writes_sent = 0;
        unused_sent = 0;
        free_run = 1'b0;
        hold_off_go = 1'b0;
        hold_off_done = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty record, presets, flag handling, saturation, extremes
        send_request(REQ_READ, CMD_REL_SOC, 16'h0000);
        send_request(REQ_READ, CMD_RUN_EMPTY, 16'hFFFF);
        send_request(REQ_READ, CMD_TEMPERATURE, 16'h0000);
        send_request(REQ_PRESET, 8'hFF, 16'hFFFF);
        send_request(REQ_READ, CMD_AVG_EMPTY, 16'h0000);
        send_request(REQ_PRESET, 8'h00, 16'd3);
        send_request(REQ_READ, CMD_SVC_FLAGS, 16'h0000);
        send_request(REQ_STATUS, 8'h00, 16'hFFFF);
        send_request(REQ_READ, CMD_SVC_FLAGS, 16'h0000);
        send_request(REQ_STATUS, 8'hFF, 16'h0000);
        send_request(REQ_READ, CMD_SVC_FLAGS, 16'hFFFF);
        send_request(REQ_SOC, 8'h00, 16'hFFFF);
        send_request(REQ_READ, CMD_REMAINING, 16'h0000);
        send_request(REQ_SOC, 8'h00, 16'h0000);
        send_request(REQ_READ, CMD_ABS_SOC, 16'h0000);
        send_request(REQ_TEMP, 8'h00, 16'h8000);
        send_request(REQ_READ, CMD_TEMPERATURE, 16'h0000);
        send_request(REQ_TEMP, 8'h00, 16'h7FFF);
        send_request(REQ_LIMIT, 8'h00, 16'hFFFF);
        send_request(REQ_READ, CMD_CHARGE_LIMIT, 16'h0000);
        send_request(3'd7, 8'hFF, 16'hFFFF);
        send_request(3'd6, CMD_SERIAL, 16'd1);
        send_request(REQ_READ, 8'hFF, 16'hFFFF);
        send_request(REQ_READ, CMD_MFG_DATE, 16'h0000);
        send_request(REQ_READ, 8'h00, 16'h0000);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == 350) hold_off_go = 1'b1;
            if (i == 700) begin
                // drain: no new beat until every result is back
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
            end
            free_run = (i >= 800 && i < 950);

            pick = $urandom_range(0, 99);
            cmd = 8'($urandom_range(0, 255));
            wv = 16'($urandom_range(0, 65535));
            if (pick < 55) begin
                rt = REQ_READ;
                if ($urandom_range(0, 9) < 8) begin
                    case ($urandom_range(0, 17))
                        0:  cmd = CMD_TEMPERATURE;
                        1:  cmd = CMD_VOLTAGE;
                        2:  cmd = CMD_CURRENT;
                        3:  cmd = CMD_AVG_CURRENT;
                        4:  cmd = CMD_REL_SOC;
                        5:  cmd = CMD_ABS_SOC;
                        6:  cmd = CMD_REMAINING;
                        7:  cmd = CMD_FULL_CAP;
                        8:  cmd = CMD_RUN_EMPTY;
                        9:  cmd = CMD_AVG_EMPTY;
                        10: cmd = CMD_STATUS;
                        11: cmd = CMD_CYCLES;
                        12: cmd = CMD_DESIGN_CAP;
                        13: cmd = CMD_DESIGN_VOLT;
                        14: cmd = CMD_MFG_DATE;
                        15: cmd = CMD_SERIAL;
                        16: cmd = CMD_SVC_FLAGS;
                        default: cmd = CMD_CHARGE_LIMIT;
                    endcase
                end
            end else if (pick < 63) begin
                rt = REQ_PRESET;
                if ($urandom_range(0, 9) < 8) wv = 16'($urandom_range(0, 4));
            end else if (pick < 73) begin
                rt = REQ_STATUS;
            end else if (pick < 83) begin
                rt = REQ_SOC;
                if ($urandom_range(0, 9) < 7) wv = 16'($urandom_range(0, 110));
            end else if (pick < 90) begin
                rt = REQ_TEMP;
                // realistic -40..85 C half the time
                if ($urandom_range(0, 1) == 0) wv = 16'($urandom_range(0, 125) - 40);
            end else if (pick < 95) begin
                rt = REQ_LIMIT;
            end else begin
                rt = 3'($urandom_range(6, 7));
            end
            send_request(rt, cmd, wv);
        end
        free_run = 1'b0;

        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("covered %0d requests: %0d reads, %0d writes, %0d unused types",
                 reads_sent + writes_sent + unused_sent, reads_sent, writes_sent,
                 unused_sent);
        $display("%0d result beats checked, including a %0d-cycle hold-off and a drain",
                 results_checked, LONG_HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_smart_battery_data_responder: done, clean");
        end else begin
            $display("tb_smart_battery_data_responder: done, errors");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("timeout waiting for the responder");
        $display("tb_smart_battery_data_responder: done, errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/sbr_pkg.sv
hw/rtl/sbr_div.sv
hw/rtl/smart_battery_data_responder.sv
verif/sbr_word_checker.sv
verif/tb_smart_battery_data_responder.sv
